// ----- src/fwrs_pkg.sv -----
// Package: shared types and constants of the rule scheduler.
`default_nettype none
package fwrs_pkg;

  localparam int unsigned WeightMax = 100;

  typedef enum logic [2:0] {
    FUNC_REGISTER = 3'd0,
    FUNC_NEXT     = 3'd1,
    FUNC_RECORD   = 3'd2,
    FUNC_EXHAUST  = 3'd3,
    FUNC_REPRIO   = 3'd4,
    FUNC_RESET    = 3'd5
  } func_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NONE    = 2'd1,
    ST_FULL    = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_EXEC,
    S_COUNT,
    S_OUT
  } state_e;

  typedef struct packed {
    logic [2:0]  func;
    logic [5:0]  slot;
    logic [15:0] rule_id;
    logic [1:0]  level;
    logic [15:0] weight;
    logic [15:0] app_limit;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [5:0]  out_slot;
    logic [15:0] out_rule_id;
    logic [6:0]  rule_count;
    logic [6:0]  remaining_rules;
    logic [1:0]  current_level;
  } rsp_t;

  // Ordering key: level, weight, then the stamp inverted so the smaller (older) stamp wins.
  function automatic logic [40:0] order_key(input logic [1:0] lvl, input logic [6:0] w,
                                            input logic [31:0] stamp);
    order_key = {lvl, w, ~stamp};
  endfunction

endpackage
`default_nettype wire

// ----- src/fwrs_if.sv -----
// Interfaces: request and response channels with valid/ready handshake.
`default_nettype none
interface fwrs_req_if;
  logic           valid;
  logic           ready;
  fwrs_pkg::req_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface fwrs_rsp_if;
  logic           valid;
  logic           ready;
  fwrs_pkg::rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ----- src/fwrs_cmp.sv -----
// Shared compare unit: keeps the best candidate seen during a table scan.
`default_nettype none
module fwrs_cmp #(
  parameter int unsigned IdxBits = 6
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               clear_i,
  input  wire logic               cand_i,
  input  wire logic [IdxBits-1:0] idx_i,
  input  wire logic [40:0]        key_i,
  output      logic               found_o,
  output      logic [IdxBits-1:0] best_o
);
  logic               found_q, found_d;
  logic [IdxBits-1:0] best_q, best_d;
  logic [40:0]        key_q, key_d;

  // Take the candidate when none held yet or its key is larger.
  always_comb begin
    found_d = found_q;
    best_d  = best_q;
    key_d   = key_q;
    if (clear_i) begin
      found_d = 1'b0;
    end else if (cand_i && (!found_q || key_i > key_q)) begin
      found_d = 1'b1;
      best_d  = idx_i;
      key_d   = key_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q <= 1'b0;
    end else begin
      found_q <= found_d;
    end
  end

  always_ff @(posedge clk_i) begin
    best_q <= best_d;
    key_q  <= key_d;
  end

  assign found_o = found_q;
  assign best_o  = best_q;
endmodule
`default_nettype wire

// ----- src/four_level_weighted_rule_scheduler_unit.sv -----
// Top level: rule table, sequencer and output register of the scheduler.
//
// Usage: one request beat on req (func, slot, rule_id, level, weight,
// app_limit) yields exactly one response beat on rsp. The block
// takes one request at a time; req.ready is high only when idle.
// Next and reprioritize first scan the table for the best match; every
// request then runs its table action (reset all sweeps each registered
// row) and a scan that recounts non-exhausted rules for the response.
// The block returns to idle after the response beat before the next
// request is taken. The table memory is read one entry a cycle through
// a single compare unit.
// The response stays in its register until rsp.ready is seen; a stalled
// receiver holds the block in its output state.
// Reset clears rule total, stamp counter and current level at once;
// no clearing pass is needed, the table is used in fill order.
// Apply counts saturate at 2^COUNT_BITS - 1.
// Slots are handed out in order and never freed.
`default_nettype none
module four_level_weighted_rule_scheduler_unit #(
  parameter int unsigned TABLE_ENTRIES = 64,
  parameter int unsigned COUNT_BITS    = 16
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  fwrs_req_if.sink   req,
  fwrs_rsp_if.source rsp
);
  import fwrs_pkg::*;

  localparam int unsigned IdxBits = $clog2(TABLE_ENTRIES);
  localparam int unsigned CntBits = $clog2(TABLE_ENTRIES + 1);
  localparam logic [COUNT_BITS-1:0] CountMax = '1;

  // Table memory: one packed row per slot.
  typedef struct packed {
    logic [15:0]           rule_id;
    logic [1:0]            level;
    logic [6:0]            weight;
    logic                  exhausted;
    logic [COUNT_BITS-1:0] use_count;
    logic [COUNT_BITS-1:0] limit;
    logic [31:0]           stamp;
  } row_t;

  row_t mem [TABLE_ENTRIES];
  row_t rd_q;
  logic [IdxBits-1:0] rd_addr;
  logic               wr_en;
  logic [IdxBits-1:0] wr_addr;
  row_t               wr_data;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_q <= mem[rd_addr];
  end

  state_e state_q, state_d;
  req_t   req_q;
  rsp_t   rsp_q, rsp_d;
  logic [CntBits-1:0] total_q, total_d;
  logic [31:0]        stamp_q, stamp_d;
  logic [1:0]         lastlvl_q, lastlvl_d;
  // Scan position: address issued; rd_q carries the row of the previous one.
  logic [CntBits-1:0] pos_q, pos_d;
  logic               rv_q, rv_d;
  logic [IdxBits-1:0] ridx_q, ridx_d;
  logic [CntBits-1:0] remain_q, remain_d;
  logic               exec_q, exec_d;

  logic [6:0]  wclamp;
  logic        cand;
  logic        cmp_clear;
  logic        found;
  logic [IdxBits-1:0] best;
  logic        pos_end;
  logic [COUNT_BITS-1:0] cnt_inc;
  logic [COUNT_BITS-1:0] lim_sat;
  logic        slot_ok;

  assign pos_end = (pos_q == CntBits'(TABLE_ENTRIES));
  assign slot_ok = (32'(req_q.slot) < 32'(total_q)) &&
                   (32'(req_q.slot) < TABLE_ENTRIES);

  // Clamp requested weight to 0..100.
  always_comb begin
    if (req_q.weight[15]) wclamp = '0;
    else if (req_q.weight > 16'(WeightMax)) wclamp = 7'(WeightMax);
    else wclamp = req_q.weight[6:0];
  end

  always_comb begin
    if (COUNT_BITS < 16 && req_q.app_limit > 16'(CountMax))
      lim_sat = CountMax;
    else
      lim_sat = COUNT_BITS'(req_q.app_limit);
  end

  assign cnt_inc = (rd_q.use_count < CountMax) ? rd_q.use_count + 1'b1
                                               : rd_q.use_count;

  // Candidate filter for the selection scan.
  always_comb begin
    cand = 1'b0;
    if (rv_q && (CntBits'(ridx_q) < total_q)) begin
      if (req_q.func == FUNC_NEXT) cand = !rd_q.exhausted;
      else cand = (rd_q.rule_id == req_q.rule_id);
    end
  end
  assign cmp_clear = (state_q == S_IDLE);

  fwrs_cmp #(.IdxBits(IdxBits)) u_cmp (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .clear_i (cmp_clear),
    .cand_i  (cand && state_q == S_SCAN),
    .idx_i   (ridx_q),
    .key_i   (order_key(rd_q.level, rd_q.weight, rd_q.stamp)),
    .found_o (found),
    .best_o  (best)
  );

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:  if (req.valid) begin
        if (req.data.func == FUNC_NEXT || req.data.func == FUNC_REPRIO)
          state_d = S_SCAN;
        else
          state_d = S_EXEC;
      end
      S_SCAN:  if (pos_end && !rv_q) state_d = S_EXEC;
      S_EXEC:  if (exec_q) state_d = S_COUNT;
      S_COUNT: if (pos_end && !rv_q) state_d = S_OUT;
      S_OUT:   if (rsp.ready) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // Datapath and outputs of the sequencer.
  always_comb begin
    total_d   = total_q;
    stamp_d   = stamp_q;
    lastlvl_d = lastlvl_q;
    pos_d     = pos_q;
    rv_d      = 1'b0;
    ridx_d    = pos_q[IdxBits-1:0];
    remain_d  = remain_q;
    exec_d    = 1'b0;
    rsp_d     = rsp_q;
    rd_addr   = pos_q[IdxBits-1:0];
    wr_en     = 1'b0;
    wr_addr   = IdxBits'(req_q.slot);
    wr_data   = rd_q;
    unique case (state_q)
      S_IDLE: begin
        pos_d = '0;
        if (req.valid) begin
          rsp_d = '0;
          rsp_d.status = ST_OK;
        end
      end
      S_SCAN: begin
        if (!pos_end) begin
          pos_d = pos_q + 1'b1;
          rv_d  = 1'b1;
        end else if (!rv_q) begin
          pos_d = '0;
        end
      end
      S_EXEC: begin
        // Read the target row while exec_q is low; act on it once exec_q is set.
        exec_d = !exec_q;
        unique case (req_q.func) inside
          FUNC_NEXT, FUNC_REPRIO: rd_addr = best;
          FUNC_RESET: rd_addr = pos_q[IdxBits-1:0];
          default: rd_addr = IdxBits'(req_q.slot);
        endcase
        if (exec_q) begin
          pos_d = '0;
          case (req_q.func) inside
            FUNC_REGISTER: begin
              if (32'(total_q) >= TABLE_ENTRIES) begin
                rsp_d.status = ST_FULL;
              end else begin
                wr_en   = 1'b1;
                wr_addr = total_q[IdxBits-1:0];
                wr_data.rule_id   = req_q.rule_id;
                wr_data.level     = req_q.level;
                wr_data.weight    = wclamp;
                wr_data.exhausted = 1'b0;
                wr_data.use_count = '0;
                wr_data.limit     = lim_sat;
                wr_data.stamp     = stamp_q;
                stamp_d = stamp_q + 1'b1;
                total_d = total_q + 1'b1;
                rsp_d.out_slot    = 6'(total_q);
                rsp_d.out_rule_id = req_q.rule_id;
              end
            end
            FUNC_NEXT: begin
              if (found) begin
                lastlvl_d = rd_q.level;
                rsp_d.out_slot    = 6'(best);
                rsp_d.out_rule_id = rd_q.rule_id;
              end else begin
                rsp_d.status = ST_NONE;
              end
            end
            FUNC_RECORD, FUNC_EXHAUST: begin
              if (slot_ok) begin
                wr_en = 1'b1;
                if (req_q.func == FUNC_RECORD) begin
                  wr_data.use_count = cnt_inc;
                  if (rd_q.limit != '0 && cnt_inc >= rd_q.limit)
                    wr_data.exhausted = 1'b1;
                end else begin
                  wr_data.exhausted = 1'b1;
                end
                rsp_d.out_slot    = req_q.slot;
                rsp_d.out_rule_id = rd_q.rule_id;
              end else begin
                rsp_d.status = ST_NONE;
              end
            end
            FUNC_REPRIO: begin
              if (found) begin
                if (rd_q.level != req_q.level) begin
                  wr_en   = 1'b1;
                  wr_addr = best;
                  wr_data.level = req_q.level;
                  wr_data.stamp = stamp_q;
                  stamp_d = stamp_q + 1'b1;
                end
                rsp_d.out_slot    = 6'(best);
                rsp_d.out_rule_id = rd_q.rule_id;
              end else begin
                rsp_d.status = ST_NONE;
              end
            end
            FUNC_RESET: begin
              // Sweep every registered row, reading and then writing each one.
              lastlvl_d = 2'd0;
              if (CntBits'(pos_q) < total_q) begin
                wr_en   = 1'b1;
                wr_addr = pos_q[IdxBits-1:0];
                wr_data.exhausted = 1'b0;
                wr_data.use_count = '0;
                pos_d = pos_q + 1'b1;
              end
            end
            default: ;
          endcase
        end
      end
      S_COUNT: begin
        if (!pos_end) begin
          pos_d = pos_q + 1'b1;
          rv_d  = 1'b1;
        end
        if (rv_q && CntBits'(ridx_q) < total_q && !rd_q.exhausted)
          remain_d = remain_q + 1'b1;
        rsp_d.rule_count    = 7'(total_q);
        rsp_d.current_level = lastlvl_q;
      end
      S_OUT: begin
        rsp_d.remaining_rules = 7'(remain_q);
        pos_d = '0;
      end
      default: ;
    endcase
    if (state_q == S_EXEC && exec_q) remain_d = '0;
  end

  // Keep the reset-all sweep going until every registered row is done.
  state_e state_n;
  always_comb begin
    state_n = state_d;
    if (state_q == S_EXEC && exec_q && req_q.func == FUNC_RESET &&
        CntBits'(pos_q) < total_q)
      state_n = S_EXEC;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      total_q   <= '0;
      stamp_q   <= '0;
      lastlvl_q <= '0;
      pos_q     <= '0;
      rv_q      <= 1'b0;
      exec_q    <= 1'b0;
      remain_q  <= '0;
    end else begin
      state_q   <= state_n;
      total_q   <= total_d;
      stamp_q   <= stamp_d;
      lastlvl_q <= lastlvl_d;
      pos_q     <= pos_d;
      rv_q      <= rv_d;
      exec_q    <= exec_d;
      remain_q  <= remain_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ridx_q <= ridx_d;
    rsp_q  <= rsp_d;
    if (state_q == S_IDLE && req.valid) req_q <= req.data;
  end

  assign req.ready = (state_q == S_IDLE);
  assign rsp.valid = (state_q == S_OUT);
  always_comb begin
    rsp.data = rsp_q;
    rsp.data.remaining_rules = 7'(remain_q);
  end

`ifndef SYNTHESIS
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(req.ready && rsp.valid)) else $error("request taken while response pending");
  a_total_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(total_q) <= TABLE_ENTRIES) else $error("rule total overflow");
  a_remain_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_OUT |-> remain_q <= total_q) else $error("remaining above total");
  a_total_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    total_q != $past(total_q) |-> total_q == $past(total_q) + 1'b1)
    else $error("rule total jumped");
`endif
endmodule
`default_nettype wire

// ----- test/four_level_weighted_rule_scheduler_unit_test.sv -----
// Testbench for the rule scheduler: directed table, random rule work, scoreboard against predictor.
`timescale 1ns / 100ps
`default_nettype none
module four_level_weighted_rule_scheduler_unit_test;
  import fwrs_pkg::*;

  localparam int unsigned Slots    = 64;
  localparam int unsigned CountMax = 16'hFFFF;
  localparam int unsigned RandomBeats = 1900;
  localparam longint unsigned CycleLimit = 2_000_000;

  logic clk_i;
  logic rst_ni;

  fwrs_req_if req();
  fwrs_rsp_if rsp();

  four_level_weighted_rule_scheduler_unit u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req    (req),
    .rsp    (rsp)
  );

  // Predictor state: a private copy of the rule table
  logic        tbl_valid [Slots];
  logic [15:0] tbl_id    [Slots];
  logic [1:0]  tbl_level [Slots];
  logic [6:0]  tbl_weight[Slots];
  logic        tbl_done  [Slots];
  logic [15:0] tbl_count [Slots];
  logic [15:0] tbl_limit [Slots];
  logic [31:0] tbl_stamp [Slots];
  logic [31:0] next_stamp;
  int unsigned rules_placed;
  logic [1:0]  picked_level;

  rsp_t expected_rsp_q[$];
  int   mismatch_count;
  longint unsigned cycle_count;
  bit   hold_off_rx;
  bit   quiet_tail;

  // True when entry a is scheduled ahead of entry b
  function automatic bit ranks_ahead(int a, int b);
    if (tbl_level[a] != tbl_level[b]) return tbl_level[a] > tbl_level[b];
    if (tbl_weight[a] != tbl_weight[b]) return tbl_weight[a] > tbl_weight[b];
    return tbl_stamp[a] < tbl_stamp[b];
  endfunction

  function automatic int count_live();
    int n;
    n = 0;
    for (int i = 0; i < Slots; i++) if (tbl_valid[i] && !tbl_done[i]) n++;
    return n;
  endfunction

  function automatic void clear_schedule();
    for (int i = 0; i < Slots; i++) tbl_valid[i] = 1'b0;
    next_stamp   = '0;
    rules_placed = 0;
    picked_level = '0;
  endfunction

  // Work out the answer to one request beat and advance the table
  function automatic rsp_t schedule_step(req_t r);
    rsp_t  a;
    int    best;
    bit    hit;
    logic [6:0] w;
    a = '0;
    a.status = ST_OK;
    best = 0;
    hit  = 1'b0;
    case (r.func) inside
      FUNC_REGISTER: begin
        if (rules_placed >= Slots) begin
          a.status = ST_FULL;
        end else begin
          if (r.weight[15]) w = 7'd0;
          else if (r.weight > WeightMax) w = 7'(WeightMax);
          else w = r.weight[6:0];
          tbl_valid[rules_placed]  = 1'b1;
          tbl_id[rules_placed]     = r.rule_id;
          tbl_level[rules_placed]  = r.level;
          tbl_weight[rules_placed] = w;
          tbl_done[rules_placed]   = 1'b0;
          tbl_count[rules_placed]  = '0;
          tbl_limit[rules_placed]  = r.app_limit;
          tbl_stamp[rules_placed]  = next_stamp;
          next_stamp++;
          a.out_slot    = 6'(rules_placed);
          a.out_rule_id = r.rule_id;
          rules_placed++;
        end
      end
      FUNC_NEXT: begin
        for (int i = 0; i < Slots; i++) begin
          if (!tbl_valid[i] || tbl_done[i]) continue;
          if (!hit || ranks_ahead(i, best)) begin
            best = i;
            hit  = 1'b1;
          end
        end
        if (hit) begin
          picked_level  = tbl_level[best];
          a.out_slot    = 6'(best);
          a.out_rule_id = tbl_id[best];
        end else begin
          a.status = ST_NONE;
        end
      end
      FUNC_RECORD, FUNC_EXHAUST: begin
        if (r.slot < rules_placed && tbl_valid[r.slot]) begin
          if (r.func == FUNC_RECORD) begin
            if (tbl_count[r.slot] < CountMax) tbl_count[r.slot]++;
            if (tbl_limit[r.slot] != 0 && tbl_count[r.slot] >= tbl_limit[r.slot])
              tbl_done[r.slot] = 1'b1;
          end else begin
            tbl_done[r.slot] = 1'b1;
          end
          a.out_slot    = r.slot;
          a.out_rule_id = tbl_id[r.slot];
        end else begin
          a.status = ST_NONE;
        end
      end
      FUNC_REPRIO: begin
        for (int i = 0; i < Slots; i++) begin
          if (!tbl_valid[i] || tbl_id[i] != r.rule_id) continue;
          if (!hit || ranks_ahead(i, best)) begin
            best = i;
            hit  = 1'b1;
          end
        end
        if (hit) begin
          if (tbl_level[best] != r.level) begin
            tbl_level[best] = r.level;
            tbl_stamp[best] = next_stamp;
            next_stamp++;
          end
          a.out_slot    = 6'(best);
          a.out_rule_id = tbl_id[best];
        end else begin
          a.status = ST_NONE;
        end
      end
      FUNC_RESET: begin
        for (int i = 0; i < Slots; i++) begin
          if (tbl_valid[i]) begin
            tbl_done[i]  = 1'b0;
            tbl_count[i] = '0;
          end
        end
        picked_level = '0;
      end
      default: ;
    endcase
    a.rule_count      = 7'(rules_placed);
    a.remaining_rules = 7'(count_live());
    a.current_level   = picked_level;
    return a;
  endfunction

  // Directed rows: a request and, where obvious, the answer typed in
  typedef struct {
    req_t r;
    bit   typed;
    rsp_t a;
  } row_t;

  function automatic req_t mk(logic [2:0] f, logic [5:0] s, logic [15:0] id,
                              logic [1:0] l, logic [15:0] w, logic [15:0] m);
    req_t r;
    r.func = f; r.slot = s; r.rule_id = id; r.level = l; r.weight = w;
    r.app_limit = m;
    return r;
  endfunction

  function automatic rsp_t ans(logic [1:0] st, logic [5:0] s, logic [15:0] id,
                               logic [6:0] tot, logic [6:0] rem, logic [1:0] lv);
    rsp_t a;
    a.status = st; a.out_slot = s; a.out_rule_id = id; a.rule_count = tot;
    a.remaining_rules = rem; a.current_level = lv;
    return a;
  endfunction

  row_t directed[$];

  initial begin
    // empty table: nothing to pick, nothing to record or move
    directed.push_back('{mk(FUNC_NEXT, 0, 0, 0, 0, 0), 1, ans(ST_NONE, 0, 0, 0, 0, 0)});
    directed.push_back('{mk(FUNC_RECORD, 63, 0, 0, 0, 0), 1, ans(ST_NONE, 0, 0, 0, 0, 0)});
    directed.push_back('{mk(FUNC_EXHAUST, 0, 0, 0, 0, 0), 1, ans(ST_NONE, 0, 0, 0, 0, 0)});
    directed.push_back('{mk(FUNC_REPRIO, 0, 16'hFFFF, 3, 0, 0), 1,
                         ans(ST_NONE, 0, 0, 0, 0, 0)});
    directed.push_back('{mk(FUNC_REGISTER, 0, 16'hFFFF, 3, 16'h8000, 16'hFFFF), 1,
                         ans(ST_OK, 0, 16'hFFFF, 1, 1, 0)});
    directed.push_back('{mk(FUNC_REGISTER, 0, 16'h0000, 0, 16'h7FFF, 16'h0000), 1,
                         ans(ST_OK, 1, 16'h0000, 2, 2, 0)});
    directed.push_back('{mk(FUNC_REGISTER, 0, 16'h1234, 3, 16'd100, 1), 0, '0});
    directed.push_back('{mk(FUNC_REGISTER, 0, 16'h1234, 3, 16'd100, 2), 0, '0});
    directed.push_back('{mk(FUNC_REGISTER, 0, 16'h5555, 1, 16'hFFFF, 0), 0, '0});
    directed.push_back('{mk(FUNC_NEXT, 0, 0, 0, 0, 0), 0, '0});
    directed.push_back('{mk(FUNC_RECORD, 2, 0, 0, 0, 0), 0, '0});
    directed.push_back('{mk(FUNC_NEXT, 0, 0, 0, 0, 0), 0, '0});
    directed.push_back('{mk(FUNC_RECORD, 5, 0, 0, 0, 0), 0, '0});
    directed.push_back('{mk(FUNC_REPRIO, 0, 16'h1234, 0, 0, 0), 0, '0});
    directed.push_back('{mk(FUNC_REPRIO, 0, 16'h1234, 0, 0, 0), 0, '0});
    directed.push_back('{mk(FUNC_EXHAUST, 0, 0, 0, 0, 0), 0, '0});
    directed.push_back('{mk(FUNC_REPRIO, 0, 16'hFFFF, 2, 0, 0), 0, '0});
    directed.push_back('{mk(FUNC_NEXT, 0, 0, 0, 0, 0), 0, '0});
    directed.push_back('{mk(3'd6, 6'h2A, 16'hAAAA, 2, 16'h5555, 16'hAAAA), 0, '0});
    directed.push_back('{mk(3'd7, 6'h15, 16'h5555, 1, 16'hAAAA, 16'h5555), 0, '0});
    directed.push_back('{mk(FUNC_RESET, 0, 0, 0, 0, 0), 0, '0});
    directed.push_back('{mk(FUNC_NEXT, 0, 0, 0, 0, 0), 0, '0});
  end

  // Clock and reset
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    rst_ni = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // Cycle limit
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Random request with a bias towards a useful mix
  function automatic req_t random_request(bit fill_phase);
    req_t r;
    int   pick;
    r = '0;
    r.slot  = 6'($urandom_range(0, 63));
    if ($urandom_range(0, 3) != 0 && rules_placed > 0)
      r.slot = 6'($urandom_range(0, rules_placed - 1));
    r.rule_id = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 15));
    r.level   = 2'($urandom);
    case ($urandom_range(0, 3))
      0: r.weight = 16'($urandom);
      default: r.weight = 16'($urandom_range(0, 110));
    endcase
    r.app_limit = ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                              : 16'($urandom_range(0, 4));
    pick = $urandom_range(0, 99);
    if (fill_phase && pick < 50) r.func = FUNC_REGISTER;
    else if (pick < 60) r.func = FUNC_REGISTER;
    else if (pick < 72) r.func = FUNC_NEXT;
    else if (pick < 84) r.func = FUNC_RECORD;
    else if (pick < 90) r.func = FUNC_EXHAUST;
    else if (pick < 96) r.func = FUNC_REPRIO;
    else if (pick < 99) r.func = FUNC_RESET;
    else r.func = 3'($urandom_range(6, 7));
    return r;
  endfunction

  // Offer one request beat and hold it until taken
  task automatic send_beat(req_t r, bit typed, rsp_t a, bit idle_ok);
    int gap;
    rsp_t p;
    if (idle_ok && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 11);
      req.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req.valid <= 1'b1;
    req.data  <= r;
    do @(posedge clk_i); while (!req.ready);
    p = schedule_step(r);
    expected_rsp_q.push_back(typed ? a : p);
  endtask

  // Sender
  initial begin
    rsp_t blank;
    blank = '0;
    cycle_count    = 0;
    mismatch_count = 0;
    hold_off_rx    = 1'b0;
    quiet_tail     = 1'b0;
    clear_schedule();
    req.valid = 1'b0;
    req.data  = '0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    foreach (directed[i]) send_beat(directed[i].r, directed[i].typed, directed[i].a, 1'b1);
    // fill the table to the top and beyond while the receiver holds off
    hold_off_rx = 1'b1;
    for (int i = 0; i < 70; i++) begin
      send_beat(mk(FUNC_REGISTER, 0, 16'($urandom), 2'($urandom), 16'($urandom),
                   16'($urandom_range(0, 3))), 1'b0, blank, 1'b0);
    end
    for (int i = 0; i < RandomBeats; i++) begin
      if (i == RandomBeats - 150) quiet_tail = 1'b1;
      send_beat(random_request(1'b0), 1'b0, blank, !quiet_tail);
    end
    req.valid <= 1'b0;
    while (expected_rsp_q.size() != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Receiver: random stall bursts, one long hold-off
  initial begin
    int stall;
    rsp.ready = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (hold_off_rx) begin
        rsp.ready <= 1'b0;
        repeat (400) @(posedge clk_i);
        hold_off_rx = 1'b0;
      end else if (!quiet_tail && $urandom_range(0, 7) == 0) begin
        stall = $urandom_range(1, 11);
        rsp.ready <= 1'b0;
        repeat (stall - 1) @(posedge clk_i);
      end else begin
        rsp.ready <= 1'b1;
      end
    end
  end

  // Response checker
  always @(posedge clk_i) begin
    rsp_t got, want;
    if (rst_ni && rsp.valid && rsp.ready) begin
      got = rsp.data;
      if (expected_rsp_q.size() == 0) begin
        mismatch_count <= mismatch_count + 1;
        if (mismatch_count < 10) $display("unexpected response beat %p", got);
      end else begin
        want = expected_rsp_q.pop_front();
        if (got !== want) begin
          mismatch_count <= mismatch_count + 1;
          if (mismatch_count < 10)
            $display("response mismatch: expected %p, got %p", want, got);
        end
      end
    end
  end

endmodule
`default_nettype wire
